// File: hw/rtl/crrm_pkg.sv
`timescale 1ns / 1ps

package crrm_pkg;

    // Default sizes of the rule store.
    localparam int MAX_STAGES_DEF      = 8;
    localparam int RULES_PER_STAGE_DEF = 128;

    // Field widths fixed by the item formats.
    localparam int DATA_W  = 64;
    localparam int CMD_W   = 2;
    localparam int STAGE_W = 3;
    localparam int COUNT_W = 8;
    localparam int USE_W   = 4;

    // Configuration port.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_STAGES_IN_USE = 1'b0;
    localparam logic [USE_W-1:0] STAGES_IN_USE_RST = 4'd7;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = 1;

    // Item commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND    = 2'd0,
        CMD_TRANSLATE = 2'd1,
        CMD_CLEAR     = 2'd2,
        CMD_NOP       = 2'd3
    } t_cmd;

    // One stored rule; the offset is destination minus source, taken at load.
    typedef struct packed {
        logic [DATA_W-1:0] offset;
        logic [DATA_W-1:0] source;
        logic [DATA_W-1:0] length;
    } t_rule;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        t_cmd               kind;
        logic [STAGE_W-1:0] stage;
        t_rule              rule;
        logic [DATA_W-1:0]  value;
    } t_job;

endpackage

// File: hw/rtl/crrm_in_if.sv
`timescale 1ns / 1ps

interface crrm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [2:0]  stage;
    logic [63:0] rule_dest;
    logic [63:0] rule_source;
    logic [63:0] rule_length;
    logic [63:0] value;

    modport source (
        output valid, cmd, stage, rule_dest, rule_source, rule_length, value,
        input  ready
    );
    modport sink (
        input  valid, cmd, stage, rule_dest, rule_source, rule_length, value,
        output ready
    );
endinterface

// File: hw/rtl/crrm_out_if.sv
`timescale 1ns / 1ps

interface crrm_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] mapped_value;
    logic [63:0] smallest_so_far;

    modport source (
        output valid, mapped_value, smallest_so_far,
        input  ready
    );
    modport sink (
        input  valid, mapped_value, smallest_so_far,
        output ready
    );
endinterface

// File: hw/rtl/crrm_ram.sv
`timescale 1ns / 1ps

module crrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/crrm_front.sv
`timescale 1ns / 1ps

module crrm_front #(
    parameter int MAX_STAGES = crrm_pkg::MAX_STAGES_DEF
) (
    crrm_in_if.sink        i_in,
    input  logic           i_job_ready,
    output logic           o_job_valid,
    output crrm_pkg::t_job o_job
);

    crrm_pkg::t_cmd w_kind;
    logic           w_stage_ok;
    logic           w_keep;

    // Decode the command and check the target stage of a load.
    assign w_kind     = crrm_pkg::t_cmd'(i_in.cmd);
    assign w_stage_ok = 5'(i_in.stage) < 5'(MAX_STAGES);

    always_comb begin
        case (w_kind)
            crrm_pkg::CMD_APPEND:    w_keep = w_stage_ok;
            crrm_pkg::CMD_TRANSLATE: w_keep = 1'b1;
            crrm_pkg::CMD_CLEAR:     w_keep = 1'b1;
            default:                 w_keep = 1'b0;
        endcase
    end

    // Dropped items are taken at the same pace as kept ones.
    assign i_in.ready  = i_job_ready;
    assign o_job_valid = i_in.valid && w_keep;

    // The offset of a rule is worked out once, at load time.
    always_comb begin
        o_job.kind        = w_kind;
        o_job.stage       = i_in.stage;
        o_job.rule.offset = i_in.rule_dest - i_in.rule_source;
        o_job.rule.source = i_in.rule_source;
        o_job.rule.length = i_in.rule_length;
        o_job.value       = i_in.value;
    end

endmodule

// File: hw/rtl/crrm_queue.sv
`timescale 1ns / 1ps

module crrm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wvalid,
    output logic           o_wready,
    input  crrm_pkg::t_job i_wdata,
    output logic           o_rvalid,
    input  logic           i_rready,
    output crrm_pkg::t_job o_rdata
);

    localparam int PW = crrm_pkg::QUEUE_PW;

    crrm_pkg::t_job r_mem [crrm_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [PW:0]    r_count;
    logic           w_push;
    logic           w_pop;

    assign o_wready = r_count != (PW + 1)'(crrm_pkg::QUEUE_DEPTH);
    assign o_rvalid = r_count != '0;
    assign o_rdata  = r_mem[r_rptr];
    assign w_push   = i_wvalid && o_wready;
    assign w_pop    = o_rvalid && i_rready;

    // Storage of queued items.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (PW + 1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (PW + 1)'(1);
            end
        end
    end

endmodule

// File: hw/rtl/crrm_back.sv
`timescale 1ns / 1ps

module crrm_back #(
    parameter int MAX_STAGES      = crrm_pkg::MAX_STAGES_DEF,
    parameter int RULES_PER_STAGE = crrm_pkg::RULES_PER_STAGE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_job_valid,
    output logic                        o_job_ready,
    input  crrm_pkg::t_job              i_job,
    input  logic [crrm_pkg::USE_W-1:0]  i_stages_in_use,
    crrm_out_if.source                  o_out
);

    localparam int SLOTS = MAX_STAGES * RULES_PER_STAGE;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SW    = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int UW    = $clog2(MAX_STAGES + 1);
    localparam int CW    = crrm_pkg::COUNT_W;
    localparam int DW    = crrm_pkg::DATA_W;
    localparam int SLW   = AW + CW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_counts [MAX_STAGES];
    logic [CW-1:0]   n_counts [MAX_STAGES];
    logic [SW-1:0]   r_stage, n_stage;
    logic [UW-1:0]   r_used, n_used;
    logic [AW-1:0]   r_base, n_base;
    logic [CW-1:0]   r_n, n_n;
    logic            r_pend, n_pend;
    logic [DW-1:0]   r_val, n_val;
    logic [DW-1:0]   r_min, n_min;
    logic            r_out_valid, n_out_valid;
    logic [DW-1:0]   r_out_val, n_out_val;
    logic [DW-1:0]   r_out_min, n_out_min;

    logic [SW-1:0]   w_cnt_idx;
    logic [CW-1:0]   w_cnt;
    logic [UW-1:0]   w_used;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [AW-1:0]   w_raddr;
    crrm_pkg::t_rule w_rd;
    logic            w_issue;
    logic            w_hit;
    logic            w_stage_end;
    logic [DW-1:0]   w_new_min;

    // Rule store: one word per rule slot, stage-major.
    crrm_ram #(
        .WIDTH ($bits(crrm_pkg::t_rule)),
        .DEPTH (SLOTS)
    ) u_rules (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_job.rule),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    // One read of the rule counts: the walked stage during the walk, else the load target.
    assign w_cnt_idx = (r_state == S_WALK) ? r_stage : SW'(i_job.stage);
    assign w_cnt     = r_counts[w_cnt_idx];

    // Stage count in use, held to the size of the chain.
    assign w_used = (5'(i_stages_in_use) > 5'(MAX_STAGES)) ? UW'(MAX_STAGES)
                                                          : UW'(i_stages_in_use);

    // Slot addresses for a load and for the walk.
    assign w_waddr = AW'(SLW'(i_job.stage) * SLW'(RULES_PER_STAGE) + SLW'(w_cnt));
    assign w_raddr = AW'(SLW'(r_base) + SLW'(r_n));

    // Walk: one rule read issued per cycle, its data checked in the following cycle.
    assign w_issue     = r_n < w_cnt;
    assign w_hit       = r_pend && (r_val >= w_rd.source)
                         && ((r_val - w_rd.source) < w_rd.length);
    assign w_stage_end = w_hit || (!r_pend && !w_issue);
    assign w_new_min   = (r_val < r_min) ? r_val : r_min;

    assign o_job_ready = (r_state == S_IDLE);
    assign w_we        = (r_state == S_IDLE) && i_job_valid
                         && (i_job.kind == crrm_pkg::CMD_APPEND)
                         && (w_cnt < CW'(RULES_PER_STAGE));

    // Next-state logic of the sequencer.
    always_comb begin
        n_state     = r_state;
        n_counts    = r_counts;
        n_stage     = r_stage;
        n_used      = r_used;
        n_base      = r_base;
        n_n         = r_n;
        n_pend      = r_pend;
        n_val       = r_val;
        n_min       = r_min;
        n_out_valid = r_out_valid;
        n_out_val   = r_out_val;
        n_out_min   = r_out_min;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    case (i_job.kind)
                        crrm_pkg::CMD_APPEND: begin
                            if (w_we) begin
                                n_counts[w_cnt_idx] = w_cnt + CW'(1);
                            end
                        end
                        crrm_pkg::CMD_TRANSLATE: begin
                            n_val   = i_job.value;
                            n_stage = '0;
                            n_base  = '0;
                            n_n     = '0;
                            n_pend  = 1'b0;
                            n_used  = w_used;
                            n_state = (w_used == '0) ? S_DONE : S_WALK;
                        end
                        crrm_pkg::CMD_CLEAR: begin
                            for (int i = 0; i < MAX_STAGES; i++) begin
                                n_counts[i] = '0;
                            end
                            n_min = '1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                n_pend = w_issue;
                if (w_issue) begin
                    n_n = r_n + CW'(1);
                end
                if (w_hit) begin
                    n_val = r_val + w_rd.offset;
                end
                if (w_stage_end) begin
                    if ((UW'(r_stage) + UW'(1)) == r_used) begin
                        n_state = S_DONE;
                    end else begin
                        n_stage = r_stage + SW'(1);
                        n_base  = r_base + AW'(RULES_PER_STAGE);
                        n_n     = '0;
                        n_pend  = 1'b0;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_min       = w_new_min;
                    n_out_valid = 1'b1;
                    n_out_val   = r_val;
                    n_out_min   = w_new_min;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_counts    <= '{default: '0};
            r_min       <= '1;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_counts    <= n_counts;
            r_min       <= n_min;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
        r_stage   <= n_stage;
        r_used    <= n_used;
        r_base    <= n_base;
        r_n       <= n_n;
        r_val     <= n_val;
        r_out_val <= n_out_val;
        r_out_min <= n_out_min;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.mapped_value    = r_out_val;
    assign o_out.smallest_so_far = r_out_min;

    // A clear leaves the running minimum at all ones.
    a_clear_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_job_valid && i_job.kind == crrm_pkg::CMD_CLEAR)
        |=> (r_min == '1))
        else $error("running minimum not reset by clear");

    // The reported minimum never exceeds the value reported with it.
    a_min_le_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_min <= r_out_val))
        else $error("reported minimum above mapped value");

    // The walk stays inside the stages in use.
    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (UW'(r_stage) < r_used))
        else $error("walk beyond stages in use");

    // No stage ever holds more rules than it has slots.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (w_cnt <= CW'(RULES_PER_STAGE)))
        else $error("rule count above stage capacity");

endmodule

// File: hw/rtl/chained_range_remap_min.sv
`timescale 1ns / 1ps

// Chained range remapper with running minimum.
// Input channel i_in carries one item per handshake: cmd 0 appends a rule
// (rule_dest, rule_source, rule_length) to stage "stage", cmd 1 translates
// "value" through the stages in use, cmd 2 empties all stages and resets the
// minimum. Only a translate item yields a result on o_out: the mapped value
// and the smallest mapped value since reset or the last clear.
// The APB port holds stages_in_use at byte address 0 (reset 7).
// Items pass a two-entry queue into a sequencer. A translate item walks the
// stages in use in order; in each stage it stops at the first matching rule,
// or at the end of the stage when none of its rules match. An empty stage is
// passed over. The rule memory yields one rule per cycle and the rules are
// scanned in order.
// Reset empties all stages, sets the minimum to all ones and drops any
// queued item. When the receiver stalls, the result waits in the output
// register; the sequencer keeps taking loads and clears meanwhile, and a
// further translate result waits in the sequencer until the register frees.

module chained_range_remap_min #(
    parameter int MAX_STAGES      = crrm_pkg::MAX_STAGES_DEF,
    parameter int RULES_PER_STAGE = crrm_pkg::RULES_PER_STAGE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    crrm_in_if.sink                      i_in,
    crrm_out_if.source                   o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [crrm_pkg::APB_AW-1:0]  paddr,
    input  logic [crrm_pkg::APB_DW-1:0]  pwdata,
    output logic [crrm_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    logic [crrm_pkg::USE_W-1:0] r_stages_in_use;
    logic                       w_reg_hit;
    logic                       w_fq_valid;
    logic                       w_fq_ready;
    crrm_pkg::t_job             w_fq_job;
    logic                       w_qb_valid;
    logic                       w_qb_ready;
    crrm_pkg::t_job             w_qb_job;

    // Configuration register.
    assign pready    = 1'b1;
    assign w_reg_hit = paddr[2] == crrm_pkg::REG_STAGES_IN_USE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stages_in_use <= crrm_pkg::STAGES_IN_USE_RST;
        end else if (psel && penable && pwrite && w_reg_hit) begin
            r_stages_in_use <= pwdata[crrm_pkg::USE_W-1:0];
        end
    end

    assign prdata = w_reg_hit ? crrm_pkg::APB_DW'(r_stages_in_use) : '0;

    // Front: decode and precompute rule offsets.
    crrm_front #(
        .MAX_STAGES (MAX_STAGES)
    ) u_front (
        .i_in        (i_in),
        .i_job_ready (w_fq_ready),
        .o_job_valid (w_fq_valid),
        .o_job       (w_fq_job)
    );

    // Queue between front and back.
    crrm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wvalid (w_fq_valid),
        .o_wready (w_fq_ready),
        .i_wdata  (w_fq_job),
        .o_rvalid (w_qb_valid),
        .i_rready (w_qb_ready),
        .o_rdata  (w_qb_job)
    );

    // Back: rule store, stage walk and result register.
    crrm_back #(
        .MAX_STAGES      (MAX_STAGES),
        .RULES_PER_STAGE (RULES_PER_STAGE)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (w_qb_valid),
        .o_job_ready     (w_qb_ready),
        .i_job           (w_qb_job),
        .i_stages_in_use (r_stages_in_use),
        .o_out           (o_out)
    );

endmodule
